[design/wts_pkg.sv]
// Package for the wake timer scheduler: payload structs, sleep kind and
// register index codes, reset values and rate multipliers. No dependencies.
`default_nettype none

package wts_pkg;

  localparam int TIME_BITS_DEF = 31;
  localparam int FIELD_BITS    = 31;
  localparam int DATA_BITS     = 32;
  localparam int ADDR_BITS     = 4;

  localparam logic [FIELD_BITS-1:0] BATTERY_RELOAD_RST = 31'd120000;
  localparam logic [15:0]           MIN_LIGHT_RST      = 16'd50;
  localparam logic [15:0]           MIN_DEEP_RST       = 16'd150;
  localparam logic [FIELD_BITS-1:0] FIRST_REQUEST_RST  = 31'd0;

  // Radio-on battery rate; ceil(reload / WIFI_DIV) bounds the delay with radio on
  localparam logic [4:0] WIFI_DIV = 5'd20;

  typedef enum logic [2:0] {
    SLEEP_NONE    = 3'd0,
    SLEEP_AWAKE   = 3'd1,
    SLEEP_LIGHT   = 3'd2,
    SLEEP_DEEP    = 3'd3,
    SLEEP_FOREVER = 3'd4
  } sleep_kind_t;

  typedef enum logic [1:0] {
    REG_BATTERY_RELOAD = 2'd0,
    REG_MIN_LIGHT      = 2'd1,
    REG_MIN_DEEP       = 2'd2,
    REG_FIRST_REQUEST  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] elapsed_ds;
    logic                  wifi_on;
    logic [FIELD_BITS-1:0] new_request_ds;
    logic [FIELD_BITS-1:0] new_screensaver_ds;
  } req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] delay_ds;
    logic [2:0]            sleep_kind;
    logic                  battery_due;
    logic                  request_due;
    logic                  screensaver_due;
  } rsp_t;

endpackage

`default_nettype wire

[design/wts_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Payload types come from wts_pkg.
`default_nettype none

interface wts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/wake_timer_scheduler.sv]
// Wake timer scheduler top level: input register, single-pass timer update,
// result register, APB register file and a multi-cycle divide-by-20 unit.
// Depends on wts_pkg and wts_stream_if.
//
//  channel | dir | payload              | handshake
//  --------+-----+----------------------+----------------------------
//  req     | in  | wts_pkg::req_t       | valid/ready, taken at edge
//  rsp     | out | wts_pkg::rsp_t       | valid/ready, taken at edge
//  apb     | in  | 32-bit reg writes    | psel+penable+pwrite, pready=1
//
// One request per cycle when the output is drained and the divider is idle;
// each request passes through the input register and its result is then held in the result register.
// The radio-on delay bound ceil(battery_reload / 20) is kept in a register
// produced 16 dividend bits per cycle by reciprocal multiplication after
// reset and after each battery_reload write, with req.ready low while it runs.
// A stalled output holds its result; the input register still takes one more
// request behind it, then ready drops until the result is taken.
`default_nettype none

module wake_timer_scheduler #(
  parameter int TIME_BITS = wts_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  wts_stream_if.sink                         req,
  wts_stream_if.source                       rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wts_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [wts_pkg::DATA_BITS-1:0] pwdata,
  output logic      [wts_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready
);

  localparam int T        = TIME_BITS;
  localparam int P        = TIME_BITS + 5;   // room for time * 20
  localparam int DIG      = 16;              // dividend bits per divider step
  localparam int NDIG     = (TIME_BITS + DIG - 1) / DIG;
  localparam int DVD_W    = NDIG * DIG;
  localparam int CNT_BITS = $clog2(NDIG + 1);
  localparam int FB       = wts_pkg::FIELD_BITS;

  localparam logic [T-1:0]        TMASK   = {T{1'b1}};
  localparam logic [CNT_BITS-1:0] DIV_LEN = CNT_BITS'(NDIG);
  // floor(v / 20) = (v * RECIP_20) >> 26, exact for every v below 20 * 2^16
  localparam logic [21:0]         RECIP_20 = 22'd3355444;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [T-1:0]  battery_reload;
  logic [15:0]   min_light_sleep_ds;
  logic [15:0]   min_deep_sleep_ds;
  logic [T-1:0]  first_request_ds;

  wts_pkg::reg_index_t reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = wts_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_reload     <= T'(wts_pkg::BATTERY_RELOAD_RST);
      min_light_sleep_ds <= wts_pkg::MIN_LIGHT_RST;
      min_deep_sleep_ds  <= wts_pkg::MIN_DEEP_RST;
      first_request_ds   <= T'(wts_pkg::FIRST_REQUEST_RST);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        wts_pkg::REG_BATTERY_RELOAD: battery_reload     <= T'(pwdata[FB-1:0]);
        wts_pkg::REG_MIN_LIGHT:      min_light_sleep_ds <= pwdata[15:0];
        wts_pkg::REG_MIN_DEEP:       min_deep_sleep_ds  <= pwdata[15:0];
        wts_pkg::REG_FIRST_REQUEST:  first_request_ds   <= T'(pwdata[FB-1:0]);
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wts_pkg::REG_BATTERY_RELOAD: prdata = wts_pkg::DATA_BITS'(FB'(battery_reload));
      wts_pkg::REG_MIN_LIGHT:      prdata = wts_pkg::DATA_BITS'(min_light_sleep_ds);
      wts_pkg::REG_MIN_DEEP:       prdata = wts_pkg::DATA_BITS'(min_deep_sleep_ds);
      wts_pkg::REG_FIRST_REQUEST:  prdata = wts_pkg::DATA_BITS'(FB'(first_request_ds));
    endcase
  end

  // ---------------------------------------------------------------------
  // Divide-by-20 unit: maxbat_wifi = ceil(battery_reload / 20).
  // Long division in 16-bit digits, most significant first; each digit is
  // divided by reciprocal multiplication and the remainder stays below 20.
  // ---------------------------------------------------------------------
  logic                div_busy;
  logic [CNT_BITS-1:0] div_cnt;
  logic [DVD_W-1:0]    div_dvd;
  logic [DVD_W-1:0]    div_quo;
  logic [4:0]          div_rem;
  logic [T-1:0]        maxbat_wifi;

  logic [20:0]         dig_val;
  logic [42:0]         dig_prod;
  logic [15:0]         dig_quo;
  logic [4:0]          dig_rem;

  assign dig_val  = {div_rem, div_dvd[DVD_W-1 -: DIG]};
  assign dig_prod = {22'd0, dig_val} * {21'd0, RECIP_20};
  assign dig_quo  = dig_prod[41:26];
  assign dig_rem  = 5'(dig_val - {5'd0, dig_quo} * 21'(wts_pkg::WIFI_DIV));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_LEN;
      div_dvd  <= DVD_W'(T'(wts_pkg::BATTERY_RELOAD_RST));
      div_quo  <= '0;
      div_rem  <= '0;
    end else if (cfg_wr && reg_idx == wts_pkg::REG_BATTERY_RELOAD) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_LEN;
      div_dvd  <= DVD_W'(T'(pwdata[FB-1:0]));
      div_quo  <= '0;
      div_rem  <= '0;
    end else if (div_busy) begin
      if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
        div_dvd <= div_dvd << DIG;
        div_quo <= (div_quo << DIG) | DVD_W'(dig_quo);
        div_rem <= dig_rem;
      end else begin
        // round up on a nonzero remainder
        maxbat_wifi <= T'(div_quo) + T'(div_rem != '0);
        div_busy    <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input register and result register
  // ---------------------------------------------------------------------
  logic          s1_valid;
  wts_pkg::req_t s1_data;
  logic          s1_move;
  logic          s1_fire;
  logic          in_fire;

  assign s1_move   = !rsp.valid || rsp.ready;
  assign s1_fire   = s1_valid && s1_move;
  assign req.ready = !div_busy && (!s1_valid || s1_move);
  assign in_fire   = req.valid && req.ready;

  // Timer state
  logic [T-1:0] request_timer;
  logic [T-1:0] screensaver_timer;
  logic [T-1:0] battery_timer;
  logic [T-1:0] last_delay;

  logic [T-1:0] request_timer_next;
  logic [T-1:0] screensaver_timer_next;
  logic [T-1:0] battery_timer_next;
  logic [T-1:0] last_delay_next;
  wts_pkg::rsp_t rsp_next;

  // single-pass datapath signals
  logic [T-1:0] elapsed;
  logic [T-1:0] t1;
  logic         do1;
  logic [P-1:0] p1;
  logic [T-1:0] req1, scr1, bat1;
  logic [T-1:0] maxbat;
  logic [T-1:0] dly;
  logic [P-1:0] d_ext, d_x5, p2;
  logic         do2;
  logic [T-1:0] req2, scr2, bat2;
  wts_pkg::sleep_kind_t kind;

  always_comb begin
    elapsed = T'(s1_data.elapsed_ds);

    // Phase 1: overrun beyond the previous delay, charged at radio-on rate
    do1 = elapsed > last_delay;
    t1  = elapsed - last_delay;
    p1  = (P'(t1) << 4) + (P'(t1) << 2);
    req1 = request_timer;
    scr1 = screensaver_timer;
    bat1 = battery_timer;
    if (do1) begin
      if (request_timer != TMASK) req1 = (request_timer > t1) ? request_timer - t1 : '0;
      if (screensaver_timer != TMASK)
        scr1 = (screensaver_timer > t1) ? screensaver_timer - t1 : '0;
      if (battery_timer != TMASK)
        bat1 = (P'(battery_timer) > p1) ? battery_timer - p1[T-1:0] : '0;
    end

    // Phase 2: next delay is the smallest of the three bounds
    maxbat = s1_data.wifi_on ? maxbat_wifi : battery_reload;
    dly    = req1;
    if (scr1 < dly)   dly = scr1;
    if (maxbat < dly) dly = maxbat;

    d_ext = P'(dly);
    d_x5  = (d_ext << 2) + d_ext;
    do2   = 1'b1;
    priority if (dly == '0) begin
      kind = wts_pkg::SLEEP_NONE;
      do2  = 1'b0;
      p2   = '0;
    end else if (dly == TMASK) begin
      kind = wts_pkg::SLEEP_FOREVER;
      do2  = 1'b0;
      p2   = '0;
    end else if (s1_data.wifi_on || dly < T'(min_light_sleep_ds)) begin
      kind = wts_pkg::SLEEP_AWAKE;
      p2   = s1_data.wifi_on ? (d_x5 << 2) : (d_x5 << 1);
    end else if (dly < T'(min_deep_sleep_ds)) begin
      kind = wts_pkg::SLEEP_LIGHT;
      p2   = d_x5;
    end else begin
      kind = wts_pkg::SLEEP_DEEP;
      p2   = d_ext;
    end

    req2 = req1;
    scr2 = scr1;
    bat2 = bat1;
    if (do2) begin
      if (req1 != TMASK) req2 = (req1 > dly) ? req1 - dly : '0;
      if (scr1 != TMASK) scr2 = (scr1 > dly) ? scr1 - dly : '0;
      if (bat1 != TMASK) bat2 = (P'(bat1) > p2) ? bat1 - p2[T-1:0] : '0;
    end

    // Phase 3: due events
    rsp_next                 = '0;
    request_timer_next       = req2;
    screensaver_timer_next   = scr2;
    battery_timer_next       = bat2;
    last_delay_next          = dly;
    rsp_next.delay_ds        = FB'(dly);
    rsp_next.sleep_kind      = kind;
    rsp_next.request_due     = req2 == '0;
    if (bat2 == '0) begin
      rsp_next.battery_due = 1'b1;
      battery_timer_next   = battery_reload;
    end
    if (scr2 == '0) begin
      rsp_next.screensaver_due = 1'b1;
      screensaver_timer_next   = TMASK;
    end

    // Load request: set two timers, charge nothing, report all zero
    if (s1_data.mode) begin
      rsp_next               = '0;
      request_timer_next     = T'(s1_data.new_request_ds);
      screensaver_timer_next = T'(s1_data.new_screensaver_ds);
      battery_timer_next     = battery_timer;
      last_delay_next        = last_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      rsp.valid         <= 1'b0;
      request_timer     <= T'(wts_pkg::FIRST_REQUEST_RST);
      screensaver_timer <= TMASK;
      battery_timer     <= T'(wts_pkg::BATTERY_RELOAD_RST);
      last_delay        <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        s1_data  <= req.data;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        rsp.valid         <= 1'b1;
        rsp.data          <= rsp_next;
        request_timer     <= request_timer_next;
        screensaver_timer <= screensaver_timer_next;
        battery_timer     <= battery_timer_next;
        last_delay        <= last_delay_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // No request is taken while the delay bound is being recomputed
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !req.ready)
    else $error("request taken while divider busy");

  // A battery_reload write always restarts the divider
  a_reload_restarts: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && reg_idx == wts_pkg::REG_BATTERY_RELOAD) |=> div_busy)
    else $error("divider not restarted after reload write");

  // A due screensaver leaves its timer disabled
  a_scr_disabled: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && rsp_next.screensaver_due) |=> (screensaver_timer == TMASK))
    else $error("screensaver timer not disabled after due");

  // A result of sleep kind none reports zero delay
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.sleep_kind == wts_pkg::SLEEP_NONE)
      |-> (rsp.data.delay_ds == '0))
    else $error("sleep kind none with nonzero delay");
`endif

endmodule

`default_nettype wire

[tb/sv/wts_schedule_checker.sv]
// Scoreboard for the wake timer scheduler: follows APB register writes,
// predicts one result per accepted request and compares the result channel.
// Depends on wts_pkg.
module wts_schedule_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_ready,
  input  wts_pkg::req_t                 req_data,
  input  logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  wts_pkg::rsp_t                 rsp_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [wts_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wts_pkg::DATA_BITS-1:0] pwdata,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import wts_pkg::*;

  localparam logic [FIELD_BITS-1:0] NEVER = '1;
  localparam logic [4:0] RATE_RADIO_ON  = 5'd20;
  localparam logic [4:0] RATE_RADIO_OFF = 5'd10;
  localparam logic [4:0] RATE_LIGHT     = 5'd5;
  localparam logic [4:0] RATE_DEEP      = 5'd1;

  // register copies
  logic [FIELD_BITS-1:0] reload_cfg;
  logic [15:0]           light_cfg;
  logic [15:0]           deep_cfg;
  logic [FIELD_BITS-1:0] first_cfg;

  // timer state
  logic [FIELD_BITS-1:0] request_timer;
  logic [FIELD_BITS-1:0] screensaver_timer;
  logic [FIELD_BITS-1:0] battery_timer;
  logic [FIELD_BITS-1:0] last_delay;

  rsp_t pending_results[$];
  rsp_t want;

  // disabled timers never move; live ones stop at zero
  function automatic logic [FIELD_BITS-1:0] count_down(input logic [FIELD_BITS-1:0] t,
                                                        input logic [FIELD_BITS-1:0] d);
    if (t == NEVER) return t;
    return (t > d) ? t - d : '0;
  endfunction

  function automatic void drain(input logic [FIELD_BITS-1:0] t, input logic [4:0] rate);
    logic [63:0] cost;
    cost = 64'(t) * 64'(rate);
    request_timer     = count_down(request_timer, t);
    screensaver_timer = count_down(screensaver_timer, t);
    if (battery_timer != NEVER)
      battery_timer = (cost <= 64'(NEVER) && 64'(battery_timer) > cost) ?
                      battery_timer - cost[FIELD_BITS-1:0] : '0;
  endfunction

  function automatic rsp_t schedule_step(input req_t r);
    rsp_t        res;
    logic [63:0] bound;
    logic [4:0]  rate;
    logic [FIELD_BITS-1:0] dly;
    sleep_kind_t kind;
    res = '0;
    if (r.mode) begin
      request_timer     = r.new_request_ds;
      screensaver_timer = r.new_screensaver_ds;
      return res;
    end
    // overshoot past the last sleep is billed at the radio-on rate
    if (r.elapsed_ds > last_delay) drain(r.elapsed_ds - last_delay, RATE_RADIO_ON);
    rate  = r.wifi_on ? RATE_RADIO_ON : RATE_DEEP;
    bound = (64'(reload_cfg) + 64'(rate) - 64'd1) / 64'(rate);
    dly = request_timer;
    if (screensaver_timer < dly) dly = screensaver_timer;
    if (bound < 64'(dly)) dly = bound[FIELD_BITS-1:0];
    if (dly == '0) begin
      kind = SLEEP_NONE;
    end else if (dly == NEVER) begin
      kind = SLEEP_FOREVER;
    end else if (r.wifi_on || dly < light_cfg) begin
      kind = SLEEP_AWAKE;
      drain(dly, r.wifi_on ? RATE_RADIO_ON : RATE_RADIO_OFF);
    end else if (dly < deep_cfg) begin
      kind = SLEEP_LIGHT;
      drain(dly, RATE_LIGHT);
    end else begin
      kind = SLEEP_DEEP;
      drain(dly, RATE_DEEP);
    end
    last_delay = dly;
    if (battery_timer == '0) begin
      res.battery_due = 1'b1;
      battery_timer   = reload_cfg;
    end
    if (request_timer == '0) res.request_due = 1'b1;
    if (screensaver_timer == '0) begin
      res.screensaver_due = 1'b1;
      screensaver_timer   = NEVER;
    end
    res.delay_ds   = dly;
    res.sleep_kind = kind;
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reload_cfg        = BATTERY_RELOAD_RST;
      light_cfg         = MIN_LIGHT_RST;
      deep_cfg          = MIN_DEEP_RST;
      first_cfg         = FIRST_REQUEST_RST;
      request_timer     = first_cfg;
      screensaver_timer = NEVER;
      battery_timer     = reload_cfg;
      last_delay        = '0;
      pending_results.delete();
      mismatches        = 0;
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: delay_ds %0d", rsp_data.delay_ds);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("delay_ds", want.delay_ds, rsp_data.delay_ds);
          compare_field("sleep_kind", want.sleep_kind, rsp_data.sleep_kind);
          compare_field("battery_due", want.battery_due, rsp_data.battery_due);
          compare_field("request_due", want.request_due, rsp_data.request_due);
          compare_field("screensaver_due", want.screensaver_due, rsp_data.screensaver_due);
        end
      end
      if (req_valid && req_ready) pending_results.push_back(schedule_step(req_data));
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_BATTERY_RELOAD: reload_cfg = pwdata[FIELD_BITS-1:0];
          REG_MIN_LIGHT:      light_cfg  = pwdata[15:0];
          REG_MIN_DEEP:       deep_cfg   = pwdata[15:0];
          REG_FIRST_REQUEST:  first_cfg  = pwdata[FIELD_BITS-1:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_results.size();
  end

endmodule

[tb/sv/wake_timer_scheduler_tb.sv]
// Top of the wake timer scheduler testbench: clock, reset, APB writes,
// request stimulus, result back-pressure and the verdict.
// Depends on wts_pkg, wts_stream_if, wake_timer_scheduler, wts_schedule_checker.
module wake_timer_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wts_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 78;
  localparam logic [FIELD_BITS-1:0] NEVER = '1;
  // request kinds carried in req_t.mode
  localparam logic MODE_LOOP = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  wts_stream_if #(.payload_t(req_t)) req_ch ();
  wts_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  int mismatches;
  int outstanding;
  int cycles = 0;

  // idle control: odds out of 8 (sender) and 16 (receiver) per decision;
  // calm switches all idling off for the closing stretch
  int send_idle_odds = 2;
  int stall_odds     = 2;
  bit calm           = 1'b0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wake_timer_scheduler dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wts_schedule_checker schedule_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_data    (req_ch.data),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_data    (rsp_ch.data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Hard stop; a request or result that never moves ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result back-pressure: random stall bursts of random length.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && !rst && $urandom_range(0, 15) < stall_odds) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Mostly short timers so that events fall due often; the rest are the
  // disabled value, its neighbor, zero or anything in range.
  function automatic logic [FIELD_BITS-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NEVER;
      2:       return NEVER - 1;
      3:       return FIELD_BITS'($urandom);
      default: return FIELD_BITS'($urandom_range(1, 400));
    endcase
  endfunction

  // Unused fields of each request kind carry noise; the block must ignore it.
  function automatic req_t loop_req(input logic [FIELD_BITS-1:0] elapsed, input logic wifi);
    req_t r;
    r.mode               = MODE_LOOP;
    r.elapsed_ds         = elapsed;
    r.wifi_on            = wifi;
    r.new_request_ds     = FIELD_BITS'($urandom);
    r.new_screensaver_ds = FIELD_BITS'($urandom);
    return r;
  endfunction

  function automatic req_t load_req(input logic [FIELD_BITS-1:0] request_ds,
                                    input logic [FIELD_BITS-1:0] screensaver_ds);
    req_t r;
    r.mode               = MODE_LOAD;
    r.elapsed_ds         = FIELD_BITS'($urandom);
    r.wifi_on            = 1'($urandom);
    r.new_request_ds     = request_ds;
    r.new_screensaver_ds = screensaver_ds;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests need no re-raise.
  task automatic send(input req_t r);
    if (!calm && $urandom_range(0, 7) < send_idle_odds) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.data  = r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) send(load_req(pick_time(), pick_time()));
      else send(loop_req(pick_time(), 1'($urandom)));
    end
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic write_reg(input reg_index_t idx, input logic [DATA_BITS-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Block is idle once every result is back and ready is up again
  // (ready stays low while the reload divider runs).
  task automatic settle();
    req_ch.valid = 1'b0;
    while (outstanding != 0 || !req_ch.ready) @(negedge clk);
  endtask

  // Reload goes last: its write restarts the divider, the others don't.
  task automatic configure(input logic [FIELD_BITS-1:0] reload, input logic [15:0] light,
                           input logic [15:0] deep, input logic [FIELD_BITS-1:0] first);
    settle();
    write_reg(REG_MIN_LIGHT, DATA_BITS'(light));
    write_reg(REG_MIN_DEEP, DATA_BITS'(deep));
    write_reg(REG_FIRST_REQUEST, DATA_BITS'(first));
    write_reg(REG_BATTERY_RELOAD, DATA_BITS'(reload));
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_reload();
    case ($urandom_range(0, 3))
      0:       return FIELD_BITS'($urandom_range(1, 400));
      1:       return FIELD_BITS'($urandom_range(1, 32'h7FFF_FFFE));
      2:       return BATTERY_RELOAD_RST;
      default: return FIELD_BITS'($urandom_range(1000, 200000));
    endcase
  endfunction

  function automatic logic [15:0] pick_threshold();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
  endfunction

  initial begin
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;

    repeat (12) @(negedge clk);
    rst = 1'b0;
    settle();

    // ---- directed, reset register values ----
    // request timer starts at zero, so nothing to wait for
    send(loop_req('0, 1'b0));
    // huge overshoot: battery charge overflows, timer hits zero, check due
    send(loop_req(NEVER, 1'b1));
    send(load_req(31'd100, NEVER));
    send(loop_req('0, 1'b0));         // 100 ds, light sleep
    send(loop_req(31'd100, 1'b0));    // elapsed matches last delay; request due
    send(load_req(31'd40, 31'd30));
    send(loop_req('0, 1'b1));         // radio on: awake wait, screensaver due
    send(loop_req(31'd30, 1'b0));     // 10 ds left, under light threshold
    send(load_req(31'd1000, 31'd200));
    send(loop_req('0, 1'b0));         // deep sleep
    send(loop_req(31'd500, 1'b0));    // overshoot billed at radio rate
    send(load_req(NEVER, NEVER));     // both disabled: battery bound decides
    send(loop_req('0, 1'b1));
    send(loop_req(31'd6000, 1'b0));
    send(load_req(NEVER - 1, 31'd1));
    send(loop_req('0, 1'b0));
    send(loop_req(31'd1, 1'b1));
    send(load_req('0, '0));
    send(loop_req(NEVER - 1, 1'b0));

    // ---- extremes of the registers ----
    send_idle_odds = 1;
    stall_odds     = 3;
    configure(31'd1, 16'd0, 16'd0, NEVER);
    run_random(60);

    send_idle_odds = 3;
    stall_odds     = 0;
    configure(31'h7FFF_FFFE, 16'hFFFF, 16'hFFFF, '0);
    run_random(60);

    // reload at the disabled value: radio-off bound is all ones, so idle
    // forever is reachable once both timers are off
    send_idle_odds = 0;
    stall_odds     = 2;
    configure(NEVER, MIN_LIGHT_RST, MIN_DEEP_RST, FIELD_BITS'($urandom));
    send(load_req(NEVER, NEVER));
    send(loop_req('0, 1'b0));
    send(loop_req(31'd5, 1'b1));
    send(loop_req(NEVER, 1'b0));
    run_random(40);

    // ---- random settings; last phase runs without any idling ----
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_idle_odds = $urandom_range(0, 3);
      stall_odds     = $urandom_range(0, 3);
      configure(pick_reload(), pick_threshold(), pick_threshold(), FIELD_BITS'($urandom));
      calm = (p == RANDOM_PHASES - 1);
      run_random(ITEMS_PER_PHASE);
    end

    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[files.f]
design/wts_pkg.sv
design/wts_stream_if.sv
design/wake_timer_scheduler.sv
tb/sv/wts_schedule_checker.sv
tb/sv/wake_timer_scheduler_tb.sv
